/* rtl/fedl_pkg.sv */
// Shared types and constants for the feedback echo delay line.
package fedl_pkg;

   // Register map: index taken from paddr[2].
   localparam logic REG_DELAY_DEPTH   = 1'b0;
   localparam logic REG_FEEDBACK_GAIN = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [8:0]  DELAY_DEPTH_RESET   = 9'd299;
   localparam logic [15:0] FEEDBACK_GAIN_RESET = 16'd42598;

   // Sample range.
   localparam logic [9:0] SAMPLE_MAX = 10'd1023;

   // Output queue size and index width.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = 2;

   // Request payload: one audio sample and its controls.
   typedef struct packed {
      logic [9:0] sample_in;
      logic       effect_on;
      logic [9:0] volume;
   } req_payload_type;

   // Response payload: final sample and its PWM split.
   typedef struct packed {
      logic [9:0] sample_out;
      logic [7:0] pwm_high;
      logic [7:0] pwm_low;
   } rsp_payload_type;

endpackage

/* rtl/fedl_req_if.sv */
// Valid/ready channel carrying one request.
interface fedl_req_if;
   import fedl_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/fedl_rsp_if.sv */
// Valid/ready channel carrying one response.
interface fedl_rsp_if;
   import fedl_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/feedback_echo_delay_line_unit.sv */
// Feedback echo delay line: ring memory, feedback write-back, volume scaling.
//
//   Channel   Direction  Handshake          Contents
//   req_chan  in         valid/ready        sample_in, effect_on, volume
//   rsp_chan  out        valid/ready        sample_out, pwm_high, pwm_low
//   APB       in/out     psel/penable/pready delay_depth (0x0), feedback_gain (0x4)
//
// One request is taken per cycle while the pipeline and the queue have room; its response
// passes the memory read with feedback and volume products, division and the output queue.
// Reset is synchronous and clears all control state; the echo memory needs no
// clearing pass, since a fill count marks which entries hold live data.
// A four-entry output queue absorbs response stalls; requests stop only when
// the queue plus the two pipeline stages hold four responses.
module feedback_echo_delay_line_unit #(
   parameter int DELAY_ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   fedl_req_if.sink    req_chan,
   fedl_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fedl_pkg::*;

   localparam int AW = $clog2(DELAY_ENTRIES);
   localparam int FW = $clog2(DELAY_ENTRIES + 1);
   localparam logic [AW:0]   ENTRIES_W = (AW + 1)'(DELAY_ENTRIES);
   localparam logic [AW-1:0] LAST_POS  = AW'(DELAY_ENTRIES - 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(DELAY_ENTRIES);

   // Reciprocal of the ring size, exact for every 9-bit delay setting.
   localparam int          RECIP_SHIFT = 9 + AW;
   localparam logic [10:0] RECIP = 11'(((64'd1 << RECIP_SHIFT) + 64'(DELAY_ENTRIES) - 64'd1)
                                       / 64'(DELAY_ENTRIES));

   // Reduce a delay setting modulo the ring size by reciprocal multiplication.
   function automatic logic [AW-1:0] depth_wrap(input logic [8:0] depth);
      logic [19:0] prod;
      logic [8:0]  quo;
      logic [31:0] back;
      logic [8:0]  rem;
      prod = {11'd0, depth} * {9'd0, RECIP};
      quo  = 9'(prod >> RECIP_SHIFT);
      back = {23'd0, quo} * 32'(DELAY_ENTRIES);
      rem  = depth - back[8:0];
      return AW'(rem);
   endfunction

   // Configuration registers.
   logic [8:0]    delay_depth_ff;
   logic [AW-1:0] depth_mod_ff;
   logic [15:0]   feedback_gain_ff;
   logic          csr_write;

   // Ring state: write position, start of live data and live entry count.
   logic [AW-1:0] wp_ff, wp_in;
   logic          base_ff, base_in;
   logic [FW-1:0] fill_ff, fill_in;

   // Stage 1: memory read returns.
   logic          s1_valid_ff;
   logic          s1_echo_ff;
   logic [9:0]    s1_x_ff;
   logic [9:0]    s1_vol_ff;
   logic [AW-1:0] s1_wp_ff;
   logic          s1_hit_ff;
   logic          s1_live_ff;
   logic [9:0]    mem_rdata_ff;
   logic [9:0]    wlast_ff;

   // Stage 2: scaled product awaiting division.
   logic          s2_valid_ff;
   logic [20:0]   s2_p_ff;

   // Output queue.
   logic [9:0]         outq_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]  head_ff, tail_ff;
   logic [OUT_AW:0]    count_ff, count_in;

   logic [9:0] echo_mem [DELAY_ENTRIES];

   logic          req_fire;
   logic          rsp_fire;
   logic [OUT_AW:0] in_flight;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] rd_off;
   logic [AW-1:0] base_ext;
   logic          rd_live;
   logic          fwd_hit;

   logic [9:0]         d_val;
   logic signed [11:0] d_diff;
   logic signed [28:0] fb_prod;
   logic signed [29:0] fb_num;
   logic [9:0]         wr_data;
   logic [10:0]        dry_wet;
   logic [10:0]        o_val;
   logic [20:0]        p_val;

   logic [10:0] q_hi;
   logic [11:0] q_rem;
   logic [10:0] q_val;
   logic [9:0]  v_val;
   logic [9:0]  head_v;

   // APB access: always ready, writes land on the access phase.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         REG_DELAY_DEPTH:   prdata = {23'd0, delay_depth_ff};
         REG_FEEDBACK_GAIN: prdata = {16'd0, feedback_gain_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_depth_ff   <= DELAY_DEPTH_RESET;
         depth_mod_ff     <= depth_wrap(DELAY_DEPTH_RESET);
         feedback_gain_ff <= FEEDBACK_GAIN_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_DELAY_DEPTH: begin
               delay_depth_ff <= pwdata[8:0];
               depth_mod_ff   <= depth_wrap(pwdata[8:0]);
            end
            REG_FEEDBACK_GAIN: begin
               feedback_gain_ff <= pwdata[15:0];
            end
         endcase
      end
   end

   // Admission: accept while the pipeline and the queue have room.
   assign in_flight = (OUT_AW + 1)'(s1_valid_ff) + (OUT_AW + 1)'(s2_valid_ff) + count_ff;
   assign req_chan.ready = (in_flight < (OUT_AW + 1)'(OUT_DEPTH));
   assign req_fire = req_chan.valid && req_chan.ready;

   // Read address behind the write position, and whether it holds live data.
   assign base_ext = AW'(base_ff);

   always_comb begin
      if (wp_ff >= depth_mod_ff) begin
         rd_addr = wp_ff - depth_mod_ff;
      end else begin
         rd_addr = AW'({1'b0, wp_ff} + ENTRIES_W - {1'b0, depth_mod_ff});
      end
      if (rd_addr >= base_ext) begin
         rd_off = rd_addr - base_ext;
      end else begin
         rd_off = AW'({1'b0, rd_addr} + ENTRIES_W - {1'b0, base_ext});
      end
      rd_live = (FW'(rd_off) < fill_ff);
   end

   // The previous request writes its entry on the same edge this one reads.
   assign fwd_hit = s1_valid_ff && s1_echo_ff && (s1_wp_ff == rd_addr);

   // Ring state update per request; bypass empties the ring.
   always_comb begin
      wp_in   = wp_ff;
      base_in = base_ff;
      fill_in = fill_ff;
      if (req_fire) begin
         if (req_chan.payload.effect_on) begin
            wp_in = (wp_ff == LAST_POS) ? '0 : wp_ff + AW'(1);
            if (fill_ff != FILL_FULL) begin
               fill_in = fill_ff + FW'(1);
            end
         end else begin
            wp_in   = AW'(1);
            base_in = 1'b1;
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         base_ff     <= 1'b0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         base_ff     <= base_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_echo_ff <= req_chan.payload.effect_on;
         s1_x_ff    <= req_chan.payload.sample_in;
         s1_vol_ff  <= req_chan.payload.volume;
         s1_wp_ff   <= wp_ff;
         s1_hit_ff  <= fwd_hit;
         s1_live_ff <= rd_live;
      end
   end

   // Echo memory: read on request, feedback write from stage 1.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem_rdata_ff <= echo_mem[rd_addr];
      end
      if (s1_valid_ff && s1_echo_ff) begin
         echo_mem[s1_wp_ff] <= wr_data;
         wlast_ff           <= wr_data;
      end
   end

   // Stage 1: delayed sample, feedback value and volume product.
   always_comb begin
      if (!s1_live_ff) begin
         d_val = '0;
      end else if (s1_hit_ff) begin
         d_val = wlast_ff;
      end else begin
         d_val = mem_rdata_ff;
      end
      // g*(2d - 1023) + x*2^17 is the feedback value scaled by 2^17.
      d_diff  = $signed({1'b0, d_val, 1'b0}) - 12'sd1023;
      fb_prod = $signed({13'd0, feedback_gain_ff}) * $signed({{17{d_diff[11]}}, d_diff});
      fb_num  = $signed({3'b000, s1_x_ff, 17'd0}) + {fb_prod[28], fb_prod};
      if (fb_num[29]) begin
         wr_data = '0;
      end else if (fb_num[28:27] != 2'b00) begin
         wr_data = SAMPLE_MAX;
      end else begin
         wr_data = fb_num[26:17];
      end
      // Dry plus echo minus 511.5, truncated toward zero; non-positive gives 0.
      dry_wet = {1'b0, s1_x_ff} + {1'b0, d_val};
      if (!s1_echo_ff) begin
         o_val = {1'b0, s1_x_ff};
      end else if (dry_wet >= 11'd512) begin
         o_val = dry_wet - 11'd512;
      end else begin
         o_val = '0;
      end
      p_val = {10'd0, o_val} * {11'd0, s1_vol_ff};
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_p_ff <= p_val;
      end
   end

   // Stage 2: floor(p / 1023) with saturation at 1023.
   always_comb begin
      q_hi  = s2_p_ff[20:10];
      q_rem = {2'b00, s2_p_ff[9:0]} + {1'b0, q_hi};
      q_val = q_hi + ((q_rem >= 12'd1023) ? 11'd1 : 11'd0);
      if (s2_p_ff >= 21'd1047552) begin
         v_val = SAMPLE_MAX;
      end else begin
         v_val = q_val[9:0];
      end
   end

   // Output queue.
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      count_in = count_ff;
      if (s2_valid_ff && !rsp_fire) begin
         count_in = count_ff + (OUT_AW + 1)'(1);
      end else if (!s2_valid_ff && rsp_fire) begin
         count_in = count_ff - (OUT_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (s2_valid_ff) begin
            tail_ff <= tail_ff + OUT_AW'(1);
         end
         if (rsp_fire) begin
            head_ff <= head_ff + OUT_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         outq_ff[tail_ff] <= v_val;
      end
   end

   // Response fields, the PWM split derived from the queued sample.
   assign head_v = outq_ff[head_ff];
   assign rsp_chan.valid              = (count_ff != '0);
   assign rsp_chan.payload.sample_out = head_v;
   assign rsp_chan.payload.pwm_high   = head_v[9:2];
   assign rsp_chan.payload.pwm_low    = {6'd0, head_v[1:0]} * 8'd85;

endmodule

/* rtl/fedl_checker.sv */
// Port-level checks for the feedback echo delay line, bound to the top level.
module fedl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input fedl_pkg::rsp_payload_type rsp_payload
);
   import fedl_pkg::*;

   // The high PWM byte is always the sample's upper eight bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.pwm_high == rsp_payload.sample_out[9:2]))
      else $error("pwm_high does not match sample_out");

   // The low PWM byte spreads the two low bits over the full byte range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.pwm_low == ({6'd0, rsp_payload.sample_out[1:0]} * 8'd85)))
      else $error("pwm_low does not match sample_out");

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // Reset empties the block: no response and room for a request.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

endmodule

bind feedback_echo_delay_line_unit fedl_checker u_fedl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* verif/echo_result_compare.sv */
// Watches the echo delay line's channels and register port, predicts each response and compares it.
module echo_result_compare (
   input  logic        clock,
   input  logic        reset,
   fedl_req_if         req_mon,
   fedl_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          full_scale_count,
   output int          zero_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fedl_pkg::*;

   localparam int ECHO_ENTRIES = 512;

   // Mirror of the block's state and registers.
   logic [9:0]      echo_mem [ECHO_ENTRIES];
   logic [8:0]      write_pos;
   logic [8:0]      depth_reg;
   logic [15:0]     gain_reg;
   rsp_payload_type expected_q [$];

   function automatic logic [9:0] clamp_to_sample(input longint v);
      if (v < 0) begin
         return 10'd0;
      end
      if (v > 1023) begin
         return SAMPLE_MAX;
      end
      return v[9:0];
   endfunction

   // Computes the response to one request and updates the echo memory and write position.
   function automatic rsp_payload_type predict_echo(input req_payload_type r);
      rsp_payload_type result;
      logic [8:0]      rd_pos;
      logic [9:0]      v;
      longint          x;
      longint          d;
      longint          num;
      longint          fl;
      longint          o;
      longint          scaled;
      x = longint'(r.sample_in);
      if (r.effect_on) begin
         // Delayed tap behind the write position; the 9-bit subtraction wraps the ring.
         rd_pos = write_pos - depth_reg;
         d = longint'(echo_mem[rd_pos]);
         num = x * 131072 + longint'(gain_reg) * (2 * d - 1023);
         fl = (num < 0) ? -1 : (num >>> 17);
         echo_mem[write_pos] = clamp_to_sample(fl);
         // Dry plus echo around the midpoint, truncated toward zero.
         o = (x + d >= 512) ? x + d - 512 : x + d - 511;
         write_pos = write_pos + 9'd1;
      end else begin
         // Bypass clears the whole memory and restarts the ring.
         o = x;
         for (int i = 0; i < ECHO_ENTRIES; i++) begin
            echo_mem[i] = 10'd0;
         end
         write_pos = 9'd1;
      end
      scaled = (o <= 0) ? 0 : (o * longint'(r.volume)) / 1023;
      v = clamp_to_sample(scaled);
      result.sample_out = v;
      result.pwm_high   = v[9:2];
      result.pwm_low    = 8'(v[1:0]) * 8'd85;
      return result;
   endfunction

   // Register reads return the value last written, zero extended.
   function automatic logic [31:0] register_value(input logic idx);
      if (idx == REG_FEEDBACK_GAIN) begin
         return {16'd0, gain_reg};
      end
      return {23'd0, depth_reg};
   endfunction

   // Track register traffic, queue predictions and compare responses in order.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         for (int i = 0; i < ECHO_ENTRIES; i++) begin
            echo_mem[i] = 10'd0;
         end
         write_pos = 9'd0;
         depth_reg = DELAY_DEPTH_RESET;
         gain_reg = FEEDBACK_GAIN_RESET;
         expected_q.delete();
         fail_count = 0;
         checked_count = 0;
         full_scale_count = 0;
         zero_count = 0;
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_FEEDBACK_GAIN) begin
                  gain_reg = pwdata[15:0];
               end else begin
                  depth_reg = pwdata[8:0];
               end
            end else if (prdata !== register_value(paddr[2])) begin
               $error("prdata at 0x%0h: expected %0d, got %0d", paddr,
                      register_value(paddr[2]), prdata);
               fail_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(predict_echo(req_mon.payload));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding: sample_out %0d", got.sample_out);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               checked_count++;
               if (want.sample_out == SAMPLE_MAX) begin
                  full_scale_count++;
               end
               if (want.sample_out == 10'd0) begin
                  zero_count++;
               end
               if (got.sample_out !== want.sample_out) begin
                  $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
                  fail_count++;
               end
               if (got.pwm_high !== want.pwm_high) begin
                  $error("pwm_high: expected %0d, got %0d", want.pwm_high, got.pwm_high);
                  fail_count++;
               end
               if (got.pwm_low !== want.pwm_low) begin
                  $error("pwm_low: expected %0d, got %0d", want.pwm_low, got.pwm_low);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the echo delay line test: clock, reset, stimulus, flow control and the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fedl_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int pending_count;
   int checked_count;
   int full_scale_count;
   int zero_count;
   int burst_left = 0;
   int ready_mode = 0;
   int ready_span = 0;
   int idle_cycles = 0;
   int setting_count = 0;
   int request_count = 0;

   fedl_req_if req_chan ();
   fedl_rsp_if rsp_chan ();

   always #10 clock = ~clock;

   feedback_echo_delay_line_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   echo_result_compare i_compare (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count),
      .full_scale_count (full_scale_count),
      .zero_count       (zero_count)
   );

   // Response side stalls in spans: always ready, coin flip, sparse, or long stalls.
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_span = $urandom_range(5, 80);
      end
      ready_span--;
      case (ready_mode)
         0: begin
            rsp_chan.ready <= 1'b1;
         end
         1: begin
            rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_chan.ready <= (ready_span % 16 == 0);
         end
      endcase
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Sends one request; bursts of random length are separated by random gaps.
   task automatic send_sample(input logic [9:0] sample, input logic on, input logic [9:0] vol);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{sample_in: sample, effect_on: on, volume: vol};
      do @(posedge clock); while (!req_chan.ready);
      request_count++;
   endtask

   // Random request, leaning on the extremes of the sample and volume ranges.
   task automatic send_random_sample(input int on_pct);
      logic [9:0] sample;
      logic [9:0] vol;
      case ($urandom_range(0, 7))
         0: sample = 10'd0;
         1: sample = SAMPLE_MAX;
         2: sample = 10'($urandom_range(900, 1023));
         default: sample = 10'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 7))
         0: vol = 10'd0;
         1, 2: vol = SAMPLE_MAX;
         default: vol = 10'($urandom_range(0, 1023));
      endcase
      send_sample(sample, $urandom_range(0, 99) < on_pct, vol);
   endtask

   // Lets every outstanding response arrive before the registers change.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // One register setting followed by random traffic; upper write bits carry noise.
   task automatic run_setting(input logic [8:0] depth, input logic [15:0] gain,
                              input int count, input int on_pct);
      wait_idle();
      csr_access(1'b1, REG_DELAY_DEPTH, {23'($urandom()), depth});
      csr_access(1'b1, REG_FEEDBACK_GAIN, {16'($urandom()), gain});
      csr_access(1'b0, REG_DELAY_DEPTH, 32'd0);
      csr_access(1'b0, REG_FEEDBACK_GAIN, 32'd0);
      setting_count++;
      for (int i = 0; i < count; i++) begin
         send_random_sample(on_pct);
      end
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers must read back their reset values.
      csr_access(1'b0, REG_DELAY_DEPTH, 32'd0);
      csr_access(1'b0, REG_FEEDBACK_GAIN, 32'd0);

      // Directed: bypass extremes, then echo on an empty memory around the midpoint.
      send_sample(10'd0, 1'b0, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, 1'b0, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, 1'b0, 10'd0);
      send_sample(10'd512, 1'b0, 10'd512);
      send_sample(10'd1, 1'b0, 10'd1);
      send_sample(SAMPLE_MAX, 1'b1, SAMPLE_MAX);
      send_sample(10'd0, 1'b1, SAMPLE_MAX);
      send_sample(10'd511, 1'b1, SAMPLE_MAX);
      send_sample(10'd512, 1'b1, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, 1'b1, 10'd0);
      send_sample(10'd700, 1'b1, 10'd1000);
      send_sample(10'd341, 1'b1, 10'd682);

      // Random traffic over a series of delay and gain settings, extremes included.
      run_setting(9'd1, 16'hFFFF, 150, 97);
      run_setting(9'd0, 16'h8000, 120, 95);
      run_setting(9'd511, 16'd42598, 600, 99);
      run_setting(9'd1, 16'h0000, 100, 95);
      run_setting(9'd2, 16'hFFFF, 120, 90);
      run_setting(9'($urandom_range(3, 510)), 16'($urandom()), 150, 90);
      run_setting(9'($urandom_range(0, 40)), 16'($urandom()), 150, 90);
      run_setting(DELAY_DEPTH_RESET, FEEDBACK_GAIN_RESET, 150, 95);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("testbench: %0d requests and %0d responses over %0d register settings",
               request_count, checked_count, setting_count);
      $display("testbench: %0d responses at full scale, %0d at zero", full_scale_count,
               zero_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
